/* rtl/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, constants and the exact divide-by-255 used by the converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int ChanWidth   = 8;
    localparam int HueWidth    = 11;
    localparam int HueFracBits = 8;
    localparam int SectorWidth = HueWidth - HueFracBits;
    localparam int ProdWidth   = 2 * ChanWidth;

    // Stages that the side data spends beside the channel scalers: the factor
    // stage plus the two stages inside each scaler.
    localparam int PipeDepth   = 3;

    localparam logic [ChanWidth-1:0] FullScale = 8'd255;

    typedef logic [ChanWidth-1:0]   chan_t;
    typedef logic [SectorWidth-1:0] sector_t;
    typedef logic [ProdWidth-1:0]   prod_t;

    typedef enum logic [SectorWidth-1:0] {
        SECTOR_RED_YEL = 3'd0,
        SECTOR_YEL_GRN = 3'd1,
        SECTOR_GRN_CYN = 3'd2,
        SECTOR_CYN_BLU = 3'd3,
        SECTOR_BLU_MAG = 3'd4,
        SECTOR_MAG_RED = 3'd5
    } sector_code_t;

    // Exact floor(x / 255) for any x up to 255 * 255: (x + (x >> 8) + 1) >> 8.
    function automatic chan_t div255(input prod_t x);
        logic [ProdWidth:0] sum;
        begin
            sum = {1'b0, x} + {{(ChanWidth + 1){1'b0}}, x[ProdWidth-1:ChanWidth]}
                  + {{ProdWidth{1'b0}}, 1'b1};
            div255 = sum[ProdWidth-1:ChanWidth];
        end
    endfunction

endpackage

/* rtl/hsv_to_rgb_converter_top.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Fixed-point conversion of one HSV colour to 8-bit RGB per clock.
// ----------------------------------------------------------------------------
// Usage:
//   A colour is taken at each rising edge where start is high and busy is low.
//   busy is always low, so a new colour may be presented on every cycle.
//   hue is sector * 256 + fraction; saturation and brightness use 255 as full
//   scale. Each result appears on red, green and blue for one cycle with done
//   high, in the order the colours came in.
//   Throughput is one colour per clock, set by the four-stage pipeline:
//   factor multiply, value multiply, divide by 255, and channel selection.
//   The receiver cannot stall, so results are never held back.
//   Reset clears the valid bits of every stage; colours in flight are dropped
//   and no done strobe follows until a new transfer.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [hsv2rgb_pkg::HueWidth-1:0]     hue,
    input  hsv2rgb_pkg::chan_t                   saturation,
    input  hsv2rgb_pkg::chan_t                   brightness,
    output logic                                 done,
    output hsv2rgb_pkg::chan_t                   red,
    output hsv2rgb_pkg::chan_t                   green,
    output hsv2rgb_pkg::chan_t                   blue
);

    logic accept;

    // Stage one products.
    hsv2rgb_pkg::prod_t                     sf_prod;
    logic [hsv2rgb_pkg::HueFracBits:0]      frac_comp;
    logic [hsv2rgb_pkg::ProdWidth:0]        st_prod;

    hsv2rgb_pkg::chan_t fp_next;
    hsv2rgb_pkg::chan_t fq_next;
    hsv2rgb_pkg::chan_t ft_next;
    hsv2rgb_pkg::chan_t fp_reg;
    hsv2rgb_pkg::chan_t fq_reg;
    hsv2rgb_pkg::chan_t ft_reg;

    // Side data travelling alongside the channel scalers.
    logic                 valid_reg [hsv2rgb_pkg::PipeDepth];
    hsv2rgb_pkg::chan_t   v_reg     [hsv2rgb_pkg::PipeDepth];
    hsv2rgb_pkg::sector_t sector_reg[hsv2rgb_pkg::PipeDepth];
    logic                 grey_reg  [hsv2rgb_pkg::PipeDepth];

    hsv2rgb_pkg::chan_t p_val;
    hsv2rgb_pkg::chan_t q_val;
    hsv2rgb_pkg::chan_t t_val;

    hsv2rgb_pkg::chan_t red_next;
    hsv2rgb_pkg::chan_t green_next;
    hsv2rgb_pkg::chan_t blue_next;
    hsv2rgb_pkg::chan_t red_reg;
    hsv2rgb_pkg::chan_t green_reg;
    hsv2rgb_pkg::chan_t blue_reg;
    logic               done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The fraction is at most 255, so s*f/256 stays below 255 and s*(256-f)/256
    // reaches at most 255: neither subtraction can wrap.
    assign frac_comp = 9'd256 - {1'b0, hue[hsv2rgb_pkg::HueFracBits-1:0]};
    assign sf_prod   = saturation * hue[hsv2rgb_pkg::HueFracBits-1:0];
    assign st_prod   = saturation * frac_comp;

    assign fp_next = hsv2rgb_pkg::FullScale - saturation;
    assign fq_next = hsv2rgb_pkg::FullScale
                     - sf_prod[hsv2rgb_pkg::ProdWidth-1:hsv2rgb_pkg::HueFracBits];
    assign ft_next = hsv2rgb_pkg::FullScale
                     - st_prod[hsv2rgb_pkg::ProdWidth-1:hsv2rgb_pkg::HueFracBits];

    always_ff @(posedge clk)
    begin
        fp_reg <= fp_next;
        fq_reg <= fq_next;
        ft_reg <= ft_next;
        v_reg[0]      <= brightness;
        sector_reg[0] <= hue[hsv2rgb_pkg::HueWidth-1:hsv2rgb_pkg::HueFracBits];
        grey_reg[0]   <= (saturation == '0);
        for (int i = 1; i < hsv2rgb_pkg::PipeDepth; i++)
        begin
            v_reg[i]      <= v_reg[i-1];
            sector_reg[i] <= sector_reg[i-1];
            grey_reg[i]   <= grey_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hsv2rgb_pkg::PipeDepth; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= accept;
            for (int i = 1; i < hsv2rgb_pkg::PipeDepth; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
            done_reg <= valid_reg[hsv2rgb_pkg::PipeDepth-1];
        end
    end

    hsv2rgb_chan u_chan_p (
        .clk    (clk),
        .factor (fp_reg),
        .value  (v_reg[0]),
        .scaled (p_val)
    );

    hsv2rgb_chan u_chan_q (
        .clk    (clk),
        .factor (fq_reg),
        .value  (v_reg[0]),
        .scaled (q_val)
    );

    hsv2rgb_chan u_chan_t (
        .clk    (clk),
        .factor (ft_reg),
        .value  (v_reg[0]),
        .scaled (t_val)
    );

    always_comb
    begin
        red_next   = v_reg[hsv2rgb_pkg::PipeDepth-1];
        green_next = p_val;
        blue_next  = q_val;
        if (grey_reg[hsv2rgb_pkg::PipeDepth-1])
        begin
            red_next   = v_reg[hsv2rgb_pkg::PipeDepth-1];
            green_next = v_reg[hsv2rgb_pkg::PipeDepth-1];
            blue_next  = v_reg[hsv2rgb_pkg::PipeDepth-1];
        end
        else
        begin
            unique case (sector_reg[hsv2rgb_pkg::PipeDepth-1])
                hsv2rgb_pkg::SECTOR_RED_YEL:
                begin
                    red_next   = v_reg[hsv2rgb_pkg::PipeDepth-1];
                    green_next = t_val;
                    blue_next  = p_val;
                end
                hsv2rgb_pkg::SECTOR_YEL_GRN:
                begin
                    red_next   = q_val;
                    green_next = v_reg[hsv2rgb_pkg::PipeDepth-1];
                    blue_next  = p_val;
                end
                hsv2rgb_pkg::SECTOR_GRN_CYN:
                begin
                    red_next   = p_val;
                    green_next = v_reg[hsv2rgb_pkg::PipeDepth-1];
                    blue_next  = t_val;
                end
                hsv2rgb_pkg::SECTOR_CYN_BLU:
                begin
                    red_next   = p_val;
                    green_next = q_val;
                    blue_next  = v_reg[hsv2rgb_pkg::PipeDepth-1];
                end
                hsv2rgb_pkg::SECTOR_BLU_MAG:
                begin
                    red_next   = t_val;
                    green_next = p_val;
                    blue_next  = v_reg[hsv2rgb_pkg::PipeDepth-1];
                end
                // Sector five and the out-of-range hues share the last selection.
                default:
                begin
                    red_next   = v_reg[hsv2rgb_pkg::PipeDepth-1];
                    green_next = p_val;
                    blue_next  = q_val;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("accepted colour did not produce a result after four cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##4 !done)
        else $error("result strobe without a matching transfer");

    a_value_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (accept ##4 done) |->
            (red == $past(brightness, 4) || green == $past(brightness, 4)
             || blue == $past(brightness, 4)))
        else $error("no channel carries the brightness of its colour");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && saturation == '0) |-> ##4
            (red == $past(brightness, 4) && green == $past(brightness, 4)
             && blue == $past(brightness, 4)))
        else $error("unsaturated colour did not come out grey");

endmodule

/* rtl/hsv2rgb_chan.sv */
// ----------------------------------------------------------------------------
// HSV to RGB channel scaler
// Two register stages: v * factor, then an exact truncating divide by 255.
// ----------------------------------------------------------------------------
module hsv2rgb_chan (
    input  logic                 clk,
    input  hsv2rgb_pkg::chan_t   factor,
    input  hsv2rgb_pkg::chan_t   value,
    output hsv2rgb_pkg::chan_t   scaled
);

    hsv2rgb_pkg::prod_t prod_reg;
    hsv2rgb_pkg::prod_t prod_next;
    hsv2rgb_pkg::chan_t quo_reg;
    hsv2rgb_pkg::chan_t quo_next;

    assign prod_next = value * factor;
    assign quo_next  = hsv2rgb_pkg::div255(prod_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
    end

    assign scaled = quo_reg;

endmodule

/* bench/hsv_to_rgb_converter_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives colours through the command interface back to back and with random
// gaps, predicts each RGB result independently and checks every done strobe in order.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top_test;

    typedef logic [hsv2rgb_pkg::HueWidth-1:0] hue_t;

    typedef struct packed {
        hsv2rgb_pkg::chan_t red;
        hsv2rgb_pkg::chan_t green;
        hsv2rgb_pkg::chan_t blue;
    } rgb_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    hue_t                hue;
    hsv2rgb_pkg::chan_t  saturation;
    hsv2rgb_pkg::chan_t  brightness;
    logic                done;
    hsv2rgb_pkg::chan_t  red;
    hsv2rgb_pkg::chan_t  green;
    hsv2rgb_pkg::chan_t  blue;

    rgb_t rgb_due[$];
    int   mismatch_count;

    hsv_to_rgb_converter_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("[hsv_to_rgb_converter_top] ERROR");
        $finish;
    end

    // Fixed-point conversion; every division truncates.
    function automatic rgb_t convert_hsv(hue_t h, hsv2rgb_pkg::chan_t s,
                                         hsv2rgb_pkg::chan_t v);
        rgb_t                 rgb;
        hsv2rgb_pkg::sector_t sector;
        int unsigned          frac;
        int unsigned          p;
        int unsigned          q;
        int unsigned          t;
        begin
            sector = h[hsv2rgb_pkg::HueWidth-1:hsv2rgb_pkg::HueFracBits];
            frac   = h[hsv2rgb_pkg::HueFracBits-1:0];
            p = (v * (255 - s)) / 255;
            q = (v * (255 - ((s * frac) >> hsv2rgb_pkg::HueFracBits))) / 255;
            t = (v * (255 - ((s * (256 - frac)) >> hsv2rgb_pkg::HueFracBits))) / 255;
            if (s == 0)
            begin
                rgb = '{v, v, v};
            end
            else
            begin
                case (sector)
                    hsv2rgb_pkg::SECTOR_RED_YEL:
                        rgb = '{v, hsv2rgb_pkg::chan_t'(t), hsv2rgb_pkg::chan_t'(p)};
                    hsv2rgb_pkg::SECTOR_YEL_GRN:
                        rgb = '{hsv2rgb_pkg::chan_t'(q), v, hsv2rgb_pkg::chan_t'(p)};
                    hsv2rgb_pkg::SECTOR_GRN_CYN:
                        rgb = '{hsv2rgb_pkg::chan_t'(p), v, hsv2rgb_pkg::chan_t'(t)};
                    hsv2rgb_pkg::SECTOR_CYN_BLU:
                        rgb = '{hsv2rgb_pkg::chan_t'(p), hsv2rgb_pkg::chan_t'(q), v};
                    hsv2rgb_pkg::SECTOR_BLU_MAG:
                        rgb = '{hsv2rgb_pkg::chan_t'(t), hsv2rgb_pkg::chan_t'(p), v};
                    default:
                        rgb = '{v, hsv2rgb_pkg::chan_t'(p), hsv2rgb_pkg::chan_t'(q)};
                endcase
            end
            return rgb;
        end
    endfunction

    function automatic hsv2rgb_pkg::chan_t random_level();
        int unsigned pick;
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                return 8'd0;
            else if (pick < 24)
                return 8'd255;
            else if (pick < 30)
                return 8'd1;
            else
                return hsv2rgb_pkg::chan_t'($urandom_range(255));
        end
    endfunction

    // Mostly in range, with the fraction pushed to its ends now and then and
    // an occasional hue beyond the last sector.
    function automatic hue_t random_hue();
        int unsigned pick;
        int unsigned sector;
        int unsigned frac;
        begin
            pick   = $urandom_range(99);
            sector = (pick < 6) ? $urandom_range(7, 6) : $urandom_range(5);
            frac   = $urandom_range(255);
            if (pick >= 80 && pick < 88)
                frac = 0;
            else if (pick >= 88)
                frac = 255;
            return hue_t'(sector * 256 + frac);
        end
    endfunction

    function automatic int unsigned random_gap();
        int unsigned pick;
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                return 0;
            else if (pick < 95)
                return $urandom_range(3, 1);
            else
                return $urandom_range(40, 8);
        end
    endfunction

    // Holds the start line low; the colour inputs carry junk meanwhile.
    task automatic idle_cycles(int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            start      <= 1'b0;
            hue        <= hue_t'($urandom);
            saturation <= hsv2rgb_pkg::chan_t'($urandom);
            brightness <= hsv2rgb_pkg::chan_t'($urandom);
        end
    endtask

    task automatic send_colour(hue_t h, hsv2rgb_pkg::chan_t s, hsv2rgb_pkg::chan_t v);
        @(negedge clk);
        start      <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        rgb_due.push_back(convert_hsv(h, s, v));
    endtask

    task automatic wait_drained();
        while (rgb_due.size() != 0)
            @(posedge clk);
    endtask

    // Results arrive unconditionally, so each strobe is checked on the edge
    // that ends its cycle.
    always @(posedge clk)
    begin
        rgb_t seen;
        rgb_t want;
        seen = '{red, green, blue};
        if (done === 1'b1)
        begin
            if (rgb_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result r=%0d g=%0d b=%0d",
                         $time, red, green, blue);
            end
            else
            begin
                want = rgb_due.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    $display("%0t: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                             $time, want.red, want.green, want.blue,
                             red, green, blue);
                end
            end
        end
    end

    task automatic test_directed();
        begin
            // Fraction zero in all eight sectors, including the two beyond the
            // nominal hue range, and fraction 255 in the six nominal sectors.
            for (int sec = 0; sec < 8; sec++)
                send_colour(hue_t'(sec * 256), 8'd255, 8'd255);
            for (int sec = 0; sec < 6; sec++)
                send_colour(hue_t'(sec * 256 + 255), 8'd255, 8'd255);
            send_colour(11'd2047, 8'd0, 8'd200);
            send_colour(11'd1535, 8'd0, 8'd255);
            send_colour(11'd1536, 8'd128, 8'd77);
            send_colour(11'd700, 8'd255, 8'd0);
            send_colour(11'd128, 8'd1, 8'd255);
            send_colour(11'd1023, 8'd255, 8'd1);
            send_colour(11'd640, 8'd128, 8'd128);
            send_colour(11'd0, 8'd0, 8'd0);
            idle_cycles(1);
        end
    endtask

    task automatic test_random_gaps(int unsigned count);
        begin
            repeat (count)
            begin
                send_colour(random_hue(), random_level(), random_level());
                idle_cycles(random_gap());
            end
            idle_cycles(1);
        end
    endtask

    task automatic test_back_to_back(int unsigned count);
        begin
            repeat (count)
                send_colour(random_hue(), random_level(), random_level());
            idle_cycles(1);
        end
    endtask

    // The sender stops until the pipeline has emptied, then resumes.
    task automatic test_pause_drain(int unsigned bursts);
        begin
            repeat (bursts)
            begin
                repeat ($urandom_range(12, 1))
                    send_colour(hue_t'($urandom), hsv2rgb_pkg::chan_t'($urandom),
                                hsv2rgb_pkg::chan_t'($urandom));
                idle_cycles(1);
                wait_drained();
            end
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        hue        = '0;
        saturation = '0;
        brightness = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_gaps(1000);
        test_pause_drain(20);
        test_back_to_back(400);
        test_random_gaps(300);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && rgb_due.size() == 0)
            $display("[hsv_to_rgb_converter_top] OK");
        else
            $display("[hsv_to_rgb_converter_top] ERROR");
        $finish;
    end

endmodule

/* hsv_to_rgb_converter_top.f */
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_chan.sv
rtl/hsv_to_rgb_converter_top.sv
bench/hsv_to_rgb_converter_top_test.sv
